// ----- src/kevq_pkg.sv -----
// Shared types, codes and defaults for the key event queue.
package kevq_pkg;

   // Default sizes of the held-key map and the event ring
   localparam int KEY_COUNT_DEF   = 128;
   localparam int QUEUE_DEPTH_DEF = 32;

   // Command codes of an input item
   typedef enum logic [1:0] {
      CMD_KEY    = 2'd0,
      CMD_POP    = 2'd1,
      CMD_RELALL = 2'd2,
      CMD_CLEAR  = 2'd3
   } kevq_cmd_type;

   // Status codes of a result item
   typedef enum logic [2:0] {
      ST_OK      = 3'd0,
      ST_IGNORED = 3'd1,
      ST_DROPPED = 3'd2,
      ST_EVICTED = 3'd3,
      ST_EMPTY   = 3'd4
   } kevq_status_type;

   // Input item
   typedef struct packed {
      logic [1:0] cmd;
      logic [7:0] key_code;
      logic       key_pressed;
   } kevq_req_type;

   // Result item
   typedef struct packed {
      logic [2:0] status;
      logic       event_valid;
      logic [6:0] event_code;
      logic       event_release;
      logic [4:0] queue_count;
      logic [7:0] release_count;
   } kevq_rsp_type;

   // One slot of the event ring
   typedef struct packed {
      logic       rel;
      logic [7:0] code;
   } kevq_entry_type;

   // Datapath operations issued by the controller, one per cycle
   typedef enum logic [4:0] {
      OP_NONE,
      OP_LOAD,
      OP_CLEAR,
      OP_IGNORE,
      OP_KEY_BEGIN,
      OP_SCAN_BEGIN,
      OP_SCAN_NEXT,
      OP_POP_RD,
      OP_POP_DONE,
      OP_POP_EMPTY,
      OP_ENQ_WRITE,
      OP_ENQ_DROP,
      OP_SRCH_START,
      OP_SRCH_RD,
      OP_SRCH_NEXT,
      OP_SHIFT_START,
      OP_SHIFT_RD,
      OP_SHIFT_WR,
      OP_EVICT_WRITE,
      OP_PUBLISH
   } kevq_op_type;

   // Datapath status seen by the controller
   typedef struct packed {
      logic [1:0] cmd;
      logic       in_range;
      logic       key_pressed;
      logic       key_held;
      logic       scan;
      logic       scan_held;
      logic       scan_last;
      logic       empty;
      logic       full;
      logic       entry_rel;
      logic       idx_at_wp;
      logic       nxt_at_wp;
      logic       rd_rel;
      logic       out_free;
   } kevq_sts_type;

   // Controller states
   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_POP,
      S_SCAN,
      S_ENQ,
      S_SRCH_RD,
      S_SRCH_CHK,
      S_SHIFT_RD,
      S_SHIFT_WR,
      S_FINISH
   } kevq_state_type;

endpackage

// ----- src/kevq_chan_if.sv -----
// Valid/ready channel carrying one item of a given payload type.
interface kevq_chan_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ----- src/kevq_ctrl.sv -----
// Controller state machine sequencing the key event queue datapath.
module kevq_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  kevq_pkg::kevq_sts_type sts,
   output kevq_pkg::kevq_op_type  op
);
   import kevq_pkg::*;

   kevq_state_type state_ff;
   kevq_state_type state_in;
   kevq_state_type ret_state;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and datapath operation
   always_comb begin
      state_in  = state_ff;
      op        = OP_NONE;
      req_ready = (state_ff == S_IDLE) && !reset;
      ret_state = sts.scan ? S_SCAN : S_FINISH;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid && !reset) begin
               op       = OP_LOAD;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            unique case (kevq_cmd_type'(sts.cmd))
               CMD_KEY: begin
                  if (sts.in_range && (sts.key_pressed || sts.key_held)) begin
                     op       = OP_KEY_BEGIN;
                     state_in = S_ENQ;
                  end else begin
                     op       = OP_IGNORE;
                     state_in = S_FINISH;
                  end
               end
               CMD_POP: begin
                  if (sts.empty) begin
                     op       = OP_POP_EMPTY;
                     state_in = S_FINISH;
                  end else begin
                     op       = OP_POP_RD;
                     state_in = S_POP;
                  end
               end
               CMD_RELALL: begin
                  state_in = S_SCAN;
               end
               CMD_CLEAR: begin
                  op       = OP_CLEAR;
                  state_in = S_FINISH;
               end
            endcase
         end
         S_POP: begin
            op       = OP_POP_DONE;
            state_in = S_FINISH;
         end
         // Walk the held map one key a cycle while no held key is being queued; a held key is released and queued
         S_SCAN: begin
            if (sts.scan_held) begin
               op       = OP_SCAN_BEGIN;
               state_in = S_ENQ;
            end else if (sts.scan_last) begin
               state_in = S_FINISH;
            end else begin
               op = OP_SCAN_NEXT;
            end
         end
         S_ENQ: begin
            priority if (!sts.full) begin
               op       = OP_ENQ_WRITE;
               state_in = ret_state;
            end else if (!sts.entry_rel) begin
               op       = OP_ENQ_DROP;
               state_in = ret_state;
            end else begin
               op       = OP_SRCH_START;
               state_in = S_SRCH_RD;
            end
         end
         // Search for the oldest queued press
         S_SRCH_RD: begin
            if (sts.idx_at_wp) begin
               op       = OP_ENQ_DROP;
               state_in = ret_state;
            end else begin
               op       = OP_SRCH_RD;
               state_in = S_SRCH_CHK;
            end
         end
         S_SRCH_CHK: begin
            if (!sts.rd_rel) begin
               op       = OP_SHIFT_START;
               state_in = S_SHIFT_RD;
            end else begin
               op       = OP_SRCH_NEXT;
               state_in = S_SRCH_RD;
            end
         end
         // Close the gap one entry at a time, then drop the release into the tail
         S_SHIFT_RD: begin
            if (sts.nxt_at_wp) begin
               op       = OP_EVICT_WRITE;
               state_in = ret_state;
            end else begin
               op       = OP_SHIFT_RD;
               state_in = S_SHIFT_WR;
            end
         end
         S_SHIFT_WR: begin
            op       = OP_SHIFT_WR;
            state_in = S_SHIFT_RD;
         end
         S_FINISH: begin
            if (sts.out_free) begin
               op       = OP_PUBLISH;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

// ----- src/kevq_dp.sv -----
// Datapath of the key event queue: held map, event ring, pointers, result register.
module kevq_dp #(
   parameter int KEY_COUNT   = kevq_pkg::KEY_COUNT_DEF,
   parameter int QUEUE_DEPTH = kevq_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  kevq_pkg::kevq_op_type  op,
   output kevq_pkg::kevq_sts_type sts,
   input  kevq_pkg::kevq_req_type req_payload,
   output logic                   rsp_valid,
   output kevq_pkg::kevq_rsp_type rsp_payload,
   input  logic                   rsp_ready
);
   import kevq_pkg::*;

   localparam int PW = $clog2(QUEUE_DEPTH);
   localparam int KW = $clog2(KEY_COUNT);
   localparam logic [8:0] DEPTH9 = 9'(QUEUE_DEPTH);
   localparam logic [8:0] KEYS9  = 9'(KEY_COUNT);

   function automatic logic [PW-1:0] ring_next(input logic [PW-1:0] p);
      ring_next = (p == PW'(QUEUE_DEPTH - 1)) ? '0 : p + PW'(1);
   endfunction

   // Registers
   kevq_req_type        req_ff,   req_in;
   logic [KEY_COUNT-1:0] held_ff, held_in;
   logic [PW-1:0]       wp_ff,    wp_in;
   logic [PW-1:0]       rp_ff,    rp_in;
   logic [PW-1:0]       idx_ff,   idx_in;
   logic [PW-1:0]       nxt_ff,   nxt_in;
   logic [KW-1:0]       key_ff,   key_in;
   logic                scan_ff,  scan_in;
   kevq_entry_type      entry_ff, entry_in;
   kevq_rsp_type        res_ff,   res_in;
   kevq_rsp_type        out_ff,   out_in;
   logic                out_valid_ff, out_valid_in;
   kevq_entry_type      rd_ff;

   // Event ring storage
   kevq_entry_type      event_mem [QUEUE_DEPTH];
   logic                mem_we;
   logic                mem_re;
   logic [PW-1:0]       mem_waddr;
   logic [PW-1:0]       mem_raddr;
   kevq_entry_type      mem_wdata;

   logic [KW-1:0]       code_idx;
   logic [8:0]          count9;
   logic                full;
   logic                empty;

   assign code_idx = req_ff.key_code[KW-1:0];
   assign full     = (ring_next(wp_ff) == rp_ff);
   assign empty    = (wp_ff == rp_ff);

   // Occupancy of the ring
   always_comb begin
      count9 = 9'(wp_ff) - 9'(rp_ff);
      if (wp_ff < rp_ff) begin
         count9 = count9 + DEPTH9;
      end
   end

   // Status towards the controller
   always_comb begin
      sts.cmd         = req_ff.cmd;
      sts.in_range    = ({1'b0, req_ff.key_code} < KEYS9);
      sts.key_pressed = req_ff.key_pressed;
      sts.key_held    = held_ff[code_idx];
      sts.scan        = scan_ff;
      sts.scan_held   = held_ff[key_ff];
      sts.scan_last   = (key_ff == KW'(KEY_COUNT - 1));
      sts.empty       = empty;
      sts.full        = full;
      sts.entry_rel   = entry_ff.rel;
      sts.idx_at_wp   = (idx_ff == wp_ff);
      sts.nxt_at_wp   = (nxt_ff == wp_ff);
      sts.rd_rel      = rd_ff.rel;
      sts.out_free    = !out_valid_ff || rsp_ready;
   end

   // Execute the operation of this cycle
   always_comb begin
      req_in       = req_ff;
      held_in      = held_ff;
      wp_in        = wp_ff;
      rp_in        = rp_ff;
      idx_in       = idx_ff;
      nxt_in       = nxt_ff;
      key_in       = key_ff;
      scan_in      = scan_ff;
      entry_in     = entry_ff;
      res_in       = res_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      mem_we       = 1'b0;
      mem_re       = 1'b0;
      mem_waddr    = wp_ff;
      mem_raddr    = rp_ff;
      mem_wdata    = entry_ff;
      unique case (op)
         OP_NONE: begin
         end
         OP_LOAD: begin
            req_in      = req_payload;
            res_in      = '0;
            res_in.status = ST_OK;
            key_in      = '0;
            scan_in     = (req_payload.cmd == CMD_RELALL);
         end
         OP_CLEAR: begin
            held_in = '0;
            wp_in   = '0;
            rp_in   = '0;
         end
         OP_IGNORE: begin
            res_in.status = ST_IGNORED;
         end
         OP_KEY_BEGIN: begin
            held_in[code_idx] = req_ff.key_pressed;
            entry_in.code     = req_ff.key_code;
            entry_in.rel      = !req_ff.key_pressed;
         end
         OP_SCAN_BEGIN: begin
            held_in[key_ff] = 1'b0;
            entry_in.code   = 8'(key_ff);
            entry_in.rel    = 1'b1;
         end
         OP_SCAN_NEXT: begin
            key_in = key_ff + KW'(1);
         end
         OP_POP_RD: begin
            mem_re    = 1'b1;
            mem_raddr = rp_ff;
         end
         OP_POP_DONE: begin
            res_in.event_valid   = 1'b1;
            res_in.event_code    = rd_ff.code[6:0];
            res_in.event_release = rd_ff.rel;
            rp_in                = ring_next(rp_ff);
         end
         OP_POP_EMPTY: begin
            res_in.status = ST_EMPTY;
         end
         OP_ENQ_WRITE: begin
            mem_we    = 1'b1;
            mem_waddr = wp_ff;
            mem_wdata = entry_ff;
            wp_in     = ring_next(wp_ff);
            if (scan_ff) begin
               res_in.release_count = res_ff.release_count + 8'd1;
            end else begin
               res_in.status = ST_OK;
            end
         end
         OP_ENQ_DROP: begin
            if (!scan_ff) begin
               res_in.status = ST_DROPPED;
            end
         end
         OP_SRCH_START: begin
            idx_in = rp_ff;
         end
         OP_SRCH_RD: begin
            mem_re    = 1'b1;
            mem_raddr = idx_ff;
         end
         OP_SRCH_NEXT: begin
            idx_in = ring_next(idx_ff);
         end
         OP_SHIFT_START: begin
            nxt_in = ring_next(idx_ff);
         end
         OP_SHIFT_RD: begin
            mem_re    = 1'b1;
            mem_raddr = nxt_ff;
         end
         OP_SHIFT_WR: begin
            mem_we    = 1'b1;
            mem_waddr = idx_ff;
            mem_wdata = rd_ff;
            idx_in    = nxt_ff;
            nxt_in    = ring_next(nxt_ff);
         end
         // Tail slot freed by the shift takes the release; write pointer stays
         OP_EVICT_WRITE: begin
            mem_we    = 1'b1;
            mem_waddr = idx_ff;
            mem_wdata = entry_ff;
            if (scan_ff) begin
               res_in.release_count = res_ff.release_count + 8'd1;
            end else begin
               res_in.status = ST_EVICTED;
            end
         end
         OP_PUBLISH: begin
            out_valid_in       = 1'b1;
            out_in             = res_ff;
            out_in.queue_count = count9[4:0];
         end
         default: begin
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff      <= '0;
         wp_ff        <= '0;
         rp_ff        <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         held_ff      <= held_in;
         wp_ff        <= wp_in;
         rp_ff        <= rp_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      req_ff   <= req_in;
      idx_ff   <= idx_in;
      nxt_ff   <= nxt_in;
      key_ff   <= key_in;
      scan_ff  <= scan_in;
      entry_ff <= entry_in;
      res_ff   <= res_in;
      out_ff   <= out_in;
   end

   // Event ring: one write and one registered read a cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         event_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_ff <= event_mem[mem_raddr];
      end
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_ff;

`ifndef SYNTHESIS
   a_enq_not_full: assert property (@(posedge clock) disable iff (reset)
      (op == OP_ENQ_WRITE) |-> !full)
      else $error("plain enqueue into a full ring");

   a_pop_not_empty: assert property (@(posedge clock) disable iff (reset)
      (op == OP_POP_RD) |-> !empty)
      else $error("pop read from an empty ring");

   a_evict_tail: assert property (@(posedge clock) disable iff (reset)
      (op == OP_EVICT_WRITE) |-> (ring_next(idx_ff) == wp_ff))
      else $error("evicting release not written to the last slot");

   a_shift_inside: assert property (@(posedge clock) disable iff (reset)
      (op == OP_SHIFT_WR) |-> (nxt_ff != wp_ff) && (idx_ff != wp_ff))
      else $error("gap close moved an entry from outside the queue");

   a_publish_free: assert property (@(posedge clock) disable iff (reset)
      (op == OP_PUBLISH) |-> (!out_valid_ff || rsp_ready))
      else $error("result overwritten before it was taken");
`endif

endmodule

// ----- src/key_event_queue_with_press_eviction_core.sv -----
// Top level of the key event queue with press eviction.
//
// Usage: commands arrive on req_chan (valid/ready, one item per handshake) and
// each produces exactly one result item on rsp_chan. Commands are key event,
// pop oldest event, release all held keys and clear.
// Items are handled one at a time under a controller state machine; the event
// ring is a single-port-write, registered-read memory, so every ring access
// is a controller step of its own.
// Steps from acceptance to the result appearing on rsp_chan:
//   key event: load, decode, enqueue, finish; pop: load, decode with ring
//   read, pop, finish; ignored key, clear, pop on empty: load, decode, finish;
//   release into a full ring also searches from the oldest entry for the
//   oldest press, then moves each later entry down to close the gap;
//   release all: a map walk of one key a cycle while no held key is queued,
//   plus an enqueue and any eviction for each held key.
// A finished result waits in the output register; the next item is accepted
// and worked on meanwhile, and only its own finish waits for rsp_ready.
// Reset (synchronous) empties the ring and the held map and drops any
// pending result; ring contents are not cleared and are never read unwritten.
module key_event_queue_with_press_eviction_core #(
   parameter int KEY_COUNT   = kevq_pkg::KEY_COUNT_DEF,
   parameter int QUEUE_DEPTH = kevq_pkg::QUEUE_DEPTH_DEF
) (
   input logic         clock,
   input logic         reset,
   kevq_chan_if.sink   req_chan,
   kevq_chan_if.source rsp_chan
);
   import kevq_pkg::*;

   kevq_op_type  op;
   kevq_sts_type sts;
   kevq_rsp_type rsp_payload;
   logic         rsp_valid;
   logic         req_ready;

   // Sequencer
   kevq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .sts       (sts),
      .op        (op)
   );

   // Storage and result register
   kevq_dp #(
      .KEY_COUNT   (KEY_COUNT),
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .op          (op),
      .sts         (sts),
      .req_payload (req_chan.payload),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload),
      .rsp_ready   (rsp_chan.ready)
   );

   assign req_chan.ready   = req_ready;
   assign rsp_chan.valid   = rsp_valid;
   assign rsp_chan.payload = rsp_payload;

endmodule

// ----- dv/testbench.sv -----
// Self-checking testbench for the key event queue with press eviction.
module testbench;
   import kevq_pkg::*;

   localparam int KEYS       = KEY_COUNT_DEF;
   localparam int DEPTH      = QUEUE_DEPTH_DEF;
   localparam int CYCLE_CAP  = 2_000_000;
   localparam int TAIL       = 64;
   localparam int WANT_ITEMS = 1500;
   localparam int HOLD_LEN   = 300;

   logic clock;
   logic reset;

   kevq_chan_if #(.payload_type(kevq_req_type)) req_if ();
   kevq_chan_if #(.payload_type(kevq_rsp_type)) rsp_if ();

   key_event_queue_with_press_eviction_core uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   // Commands waiting to be offered, replies waiting to be seen
   kevq_req_type key_cmd_backlog[$];
   kevq_rsp_type awaited_replies[$];

   // Shadow of the held map, the event ring and its pointers
   bit [KEYS-1:0]  held_keys;
   kevq_entry_type ring[DEPTH];
   int             ring_wr;
   int             ring_rd;

   // Held keys as the stimulus sees them, to aim releases at held keys
   bit [KEYS-1:0] typed_held;
   int            useful_items;

   int          accepted_count;
   int          replies_checked;
   int          mismatches;
   int          events_popped;
   int          evictions;
   int          drops;
   int          releases_by_relall;
   int          burst_left;
   int          gap_left;
   int          ready_mode;
   int          mode_left;
   int          hold_left;
   int          next_hold_at;
   int unsigned cycle_count;

   // Free-running clock, period 4
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic int ring_step(int p);
      return (p + 1) % DEPTH;
   endfunction

   // Remove the oldest press and close the gap behind it
   function automatic bit drop_oldest_press();
      int i;
      int n;
      i = ring_rd;
      while (i != ring_wr) begin
         if (!ring[i].rel) begin
            n = ring_step(i);
            while (n != ring_wr) begin
               ring[i] = ring[n];
               i = n;
               n = ring_step(n);
            end
            ring_wr = (ring_wr + DEPTH - 1) % DEPTH;
            return 1'b1;
         end
         i = ring_step(i);
      end
      return 1'b0;
   endfunction

   // Append one event, evicting a press when a release meets a full ring
   function automatic kevq_status_type queue_event(int code, bit rel);
      kevq_status_type st;
      st = ST_OK;
      if (ring_step(ring_wr) == ring_rd) begin
         if (!rel || !drop_oldest_press()) return ST_DROPPED;
         st = ST_EVICTED;
      end
      ring[ring_wr].code = code[7:0];
      ring[ring_wr].rel  = rel;
      ring_wr = ring_step(ring_wr);
      return st;
   endfunction

   // Work out the reply to one command and advance the shadow state
   function automatic kevq_rsp_type predict_reply(kevq_req_type req);
      kevq_rsp_type r;
      int           released;
      r = '0;
      released = 0;
      case (req.cmd)
         CMD_KEY: begin
            if (req.key_code >= KEYS) begin
               r.status = ST_IGNORED;
            end else if (req.key_pressed) begin
               held_keys[req.key_code] = 1'b1;
               r.status = queue_event(req.key_code, 1'b0);
            end else if (held_keys[req.key_code]) begin
               held_keys[req.key_code] = 1'b0;
               r.status = queue_event(req.key_code, 1'b1);
            end else begin
               r.status = ST_IGNORED;
            end
         end
         CMD_POP: begin
            if (ring_wr != ring_rd) begin
               r.event_valid   = 1'b1;
               r.event_code    = ring[ring_rd].code[6:0];
               r.event_release = ring[ring_rd].rel;
               ring_rd = ring_step(ring_rd);
            end else begin
               r.status = ST_EMPTY;
            end
         end
         CMD_RELALL: begin
            for (int k = 0; k < KEYS; k++) begin
               if (held_keys[k]) begin
                  held_keys[k] = 1'b0;
                  if (queue_event(k, 1'b1) != ST_DROPPED) released++;
               end
            end
         end
         default: begin
            held_keys = '0;
            ring_wr   = 0;
            ring_rd   = 0;
         end
      endcase
      r.queue_count   = 5'((ring_wr + DEPTH - ring_rd) % DEPTH);
      r.release_count = 8'(released);
      return r;
   endfunction

   task automatic check_field(string field, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, got %0d", field, want, got);
         mismatches++;
      end
   endtask

   // Queue a key event and note whether the block will act on it
   task automatic push_key(int code, bit down);
      kevq_req_type req;
      req.cmd         = CMD_KEY;
      req.key_code    = code[7:0];
      req.key_pressed = down;
      key_cmd_backlog.push_back(req);
      if (code < KEYS) begin
         if (down || typed_held[code]) useful_items++;
         typed_held[code] = down;
      end
   endtask

   // Queue a pop, release-all or clear with junk in the unused fields
   task automatic push_cmd(kevq_cmd_type c);
      kevq_req_type req;
      req.cmd         = c;
      req.key_code    = 8'($urandom_range(0, 255));
      req.key_pressed = 1'($urandom_range(0, 1));
      key_cmd_backlog.push_back(req);
      useful_items++;
      if (c == CMD_RELALL || c == CMD_CLEAR) typed_held = '0;
   endtask

   task automatic push_pops(int n);
      repeat (n) push_cmd(CMD_POP);
   endtask

   // Some key currently held, or -1 if none
   function automatic int pick_held_key();
      int start;
      start = $urandom_range(0, KEYS - 1);
      for (int i = 0; i < KEYS; i++) begin
         if (typed_held[(start + i) % KEYS]) return (start + i) % KEYS;
      end
      return -1;
   endfunction

   // Release a held key if there is one, otherwise a random one
   task automatic push_release();
      int k;
      k = pick_held_key();
      push_key(k < 0 ? $urandom_range(0, KEYS - 1) : k, 1'b0);
   endtask

   // Directed opening, then random scenarios
   task automatic build_stimulus();
      int n;
      int base;
      int k;
      kevq_req_type req;

      push_cmd(CMD_CLEAR);
      push_cmd(CMD_POP);
      push_key(0, 1'b1);
      push_key(KEYS - 1, 1'b1);
      push_key(KEYS, 1'b1);
      push_key(255, 1'b0);
      push_key(5, 1'b0);
      push_key(0, 1'b0);
      push_key(KEYS - 1, 1'b1);
      push_pops(3);
      push_key(64, 1'b1);
      push_key(3, 1'b1);
      push_cmd(CMD_RELALL);
      push_cmd(CMD_RELALL);
      push_pops(5);
      push_cmd(CMD_CLEAR);
      push_cmd(CMD_POP);
      push_key(KEYS - 1, 1'b0);

      while (useful_items < WANT_ITEMS) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
               // typing on a few keys with reads in between
               n = $urandom_range(4, 20);
               repeat (n) begin
                  k = $urandom_range(0, 99);
                  if (k < 30) push_key($urandom_range(0, 7), 1'($urandom_range(0, 1)));
                  else if (k < 55) push_key($urandom_range(0, KEYS - 1), 1'b1);
                  else if (k < 70) push_release();
                  else if (k < 88) push_cmd(CMD_POP);
                  else if (k < 93) push_cmd(CMD_RELALL);
                  else push_key($urandom_range(0, 255), 1'($urandom_range(0, 1)));
               end
            end
            4, 5: begin
               // fill past full, then release held keys into the full ring
               push_cmd(CMD_CLEAR);
               n = $urandom_range(28, 40);
               repeat (n) begin
                  if ($urandom_range(0, 3) == 0) push_release();
                  else push_key($urandom_range(0, KEYS - 1), 1'b1);
               end
               repeat ($urandom_range(1, 6)) push_release();
               push_pops($urandom_range(0, 35));
            end
            6: begin
               // ring full of releases only: further releases are dropped
               push_cmd(CMD_CLEAR);
               base = $urandom_range(0, KEYS - DEPTH);
               for (int i = 0; i < DEPTH - 1; i++) push_key(base + i, 1'b1);
               push_pops(DEPTH - 1);
               push_cmd(CMD_RELALL);
               k = $urandom_range(0, KEYS - 1);
               push_key(k, 1'b1);
               push_key(k, 1'b0);
               push_pops($urandom_range(0, 33));
            end
            7: begin
               // release-all into a ring packed with presses
               push_cmd(CMD_CLEAR);
               repeat ($urandom_range(20, 40)) push_key($urandom_range(0, KEYS - 1), 1'b1);
               push_cmd(CMD_RELALL);
               push_pops($urandom_range(0, 35));
            end
            8: begin
               // raw noise over every field
               repeat ($urandom_range(5, 15)) begin
                  req.cmd         = 2'($urandom_range(0, 3));
                  req.key_code    = 8'($urandom_range(0, 255));
                  req.key_pressed = 1'($urandom_range(0, 1));
                  if (req.cmd == CMD_KEY) push_key(req.key_code, req.key_pressed);
                  else push_cmd(kevq_cmd_type'(req.cmd));
               end
            end
            default: push_pops($urandom_range(1, 5));
         endcase
      end
   endtask

   // Offer commands in bursts, predict each one as it is accepted
   always @(posedge clock) begin : drive_cmds
      bit offer;
      if (reset) begin
         held_keys = '0;
         ring_wr   = 0;
         ring_rd   = 0;
         req_if.valid <= 1'b0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            awaited_replies.push_back(predict_reply(req_if.payload));
            accepted_count++;
            burst_left--;
            if (burst_left <= 0) begin
               burst_left = $urandom_range(1, 24);
               gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            end
         end
         offer = req_if.valid && !req_if.ready;
         if (!offer && gap_left > 0) begin
            gap_left--;
         end else if (!offer && key_cmd_backlog.size() != 0) begin
            req_if.payload <= key_cmd_backlog.pop_front();
            offer = 1'b1;
         end
         req_if.valid <= offer;
      end
   end

   // Check each reply against the oldest prediction; stall on a shifting pattern
   always @(posedge clock) begin : watch_replies
      kevq_rsp_type want;
      bit           take;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (awaited_replies.size() == 0) begin
            $error("reply with no command outstanding: %p", rsp_if.payload);
            mismatches++;
         end else begin
            want = awaited_replies.pop_front();
            replies_checked++;
            check_field("status", want.status, rsp_if.payload.status);
            check_field("event_valid", want.event_valid, rsp_if.payload.event_valid);
            check_field("event_code", want.event_code, rsp_if.payload.event_code);
            check_field("event_release", want.event_release, rsp_if.payload.event_release);
            check_field("queue_count", want.queue_count, rsp_if.payload.queue_count);
            check_field("release_count", want.release_count, rsp_if.payload.release_count);
            if (want.event_valid) events_popped++;
            if (want.status == ST_EVICTED) evictions++;
            if (want.status == ST_DROPPED) drops++;
            releases_by_relall += want.release_count;
         end
      end
      if (mode_left == 0) begin
         ready_mode = $urandom_range(0, 3);
         mode_left  = $urandom_range(20, 200);
      end else begin
         mode_left--;
      end
      case (ready_mode)
         0:       take = 1'b1;
         1:       take = 1'($urandom_range(0, 1));
         2:       take = ($urandom_range(0, 3) == 0);
         default: take = ($urandom_range(0, 7) != 0);
      endcase
      rsp_if.ready <= !reset && hold_left == 0 && take;
   end

   // Hold off the receiver now and then so the block backs up onto its input
   always @(posedge clock) begin : long_hold
      if (reset) begin
         hold_left <= 0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
      end else if (accepted_count >= next_hold_at) begin
         hold_left <= HOLD_LEN;
         next_hold_at = next_hold_at + 500;
      end
   end

   // Stop a hung run
   always @(posedge clock) begin : watchdog
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_CAP) begin
         $display("key_event_queue_with_press_eviction_core: mismatch");
         $finish;
      end
   end

   initial begin
      clock          = 1'b0;
      reset          = 1'b1;
      req_if.valid   = 1'b0;
      req_if.payload = '0;
      rsp_if.ready   = 1'b0;
      burst_left     = 8;
      next_hold_at   = 200;
      build_stimulus();

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // drain: everything accepted and answered, then a quiet tail
      while (key_cmd_backlog.size() != 0 || req_if.valid || awaited_replies.size() != 0)
         @(posedge clock);
      repeat (TAIL) @(posedge clock);

      $display("%0d commands driven, %0d replies checked, %0d events popped",
               accepted_count, replies_checked, events_popped);
      $display("%0d presses evicted, %0d events dropped, %0d releases from release-all",
               evictions, drops, releases_by_relall);
      if (mismatches == 0) begin
         $display("key_event_queue_with_press_eviction_core: match");
      end else begin
         $display("key_event_queue_with_press_eviction_core: mismatch");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
src/kevq_pkg.sv
src/kevq_chan_if.sv
src/kevq_ctrl.sv
src/kevq_dp.sv
src/key_event_queue_with_press_eviction_core.sv
dv/testbench.sv
